### hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator: defaults,
// register indexes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int unsigned HEAP_BYTES_DEF    = 65536;
   localparam int unsigned GRANULE_BYTES_DEF = 32;
   localparam int unsigned HEADER_BYTES_DEF  = 32;

   localparam int unsigned REQ_W      = 17;
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned THR_W      = 17;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 56;

   localparam logic [THR_W-1:0]  SPLIT_THRESHOLD_RST = 17'd64;
   localparam logic [ADDR_W-1:0] HEAP_BASE_RST       = 32'd0;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic {
      RSP_DONE = 1'b0,
      RSP_OOM  = 1'b1
   } rsp_status_type;

   typedef enum logic {
      CSR_SPLIT_THRESHOLD = 1'b0,
      CSR_HEAP_BASE       = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_NEED,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_SPLIT,
      ST_NEXT_RD,
      ST_NEXT_CHK,
      ST_FREE_WR,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_USE_CUR,
      WR_SPLIT_CUR,
      WR_SPLIT_NEW,
      WR_APPEND,
      WR_FREE
   } wr_op_type;

   typedef enum logic [2:0] {
      RES_KEEP,
      RES_ZERO,
      RES_OOM,
      RES_CUR,
      RES_TOP
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        calc_mul;
      logic        calc_need;
      logic        rd_cur;
      logic        rd_next;
      logic        advance;
      logic        hold_next;
      logic        merge_next;
      wr_op_type   wr_op;
      res_sel_type res_sel;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic at_top;
      logic full;
      logic fit;
      logic split_ok;
      logic hit;
      logic hit_used;
      logic next_exists;
      logic out_free;
   } dp_status_type;

endpackage

### hw/rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer of the allocator: size rounding, block walk, split, append and
// free with merge, then hand-off of the item to the output register.
// ----------------------------------------------------------------------------
module ffha_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ffha_pkg::dp_status_type status,
   output ffha_pkg::cmd_type       cmd
);

   ffha_pkg::state_type state_ff;
   ffha_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ffha_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ffha_pkg::ST_MUL;
            end
         end
         ffha_pkg::ST_MUL: begin
            if (status.is_free) begin
               state_in = ffha_pkg::ST_WALK_RD;
            end else begin
               cmd.calc_mul = 1'b1;
               state_in     = ffha_pkg::ST_NEED;
            end
         end
         ffha_pkg::ST_NEED: begin
            cmd.calc_need = 1'b1;
            state_in      = ffha_pkg::ST_WALK_RD;
         end
         ffha_pkg::ST_WALK_RD: begin
            if (status.at_top) begin
               state_in = ffha_pkg::ST_DONE;
               if (status.is_free) begin
                  cmd.res_sel = ffha_pkg::RES_ZERO;
               end else if (status.full) begin
                  cmd.res_sel = ffha_pkg::RES_OOM;
               end else begin
                  cmd.wr_op   = ffha_pkg::WR_APPEND;
                  cmd.res_sel = ffha_pkg::RES_TOP;
               end
            end else begin
               cmd.rd_cur = 1'b1;
               state_in   = ffha_pkg::ST_WALK_CHK;
            end
         end
         ffha_pkg::ST_WALK_CHK: begin
            if (status.is_free) begin
               if (!status.hit) begin
                  cmd.advance = 1'b1;
                  state_in    = ffha_pkg::ST_WALK_RD;
               end else if (status.hit_used) begin
                  cmd.hold_next = 1'b1;
                  state_in      = ffha_pkg::ST_NEXT_RD;
               end else begin
                  cmd.res_sel = ffha_pkg::RES_ZERO;
                  state_in    = ffha_pkg::ST_DONE;
               end
            end else if (!status.fit) begin
               cmd.advance = 1'b1;
               state_in    = ffha_pkg::ST_WALK_RD;
            end else if (status.split_ok) begin
               cmd.wr_op   = ffha_pkg::WR_SPLIT_CUR;
               cmd.res_sel = ffha_pkg::RES_CUR;
               state_in    = ffha_pkg::ST_SPLIT;
            end else begin
               cmd.wr_op   = ffha_pkg::WR_USE_CUR;
               cmd.res_sel = ffha_pkg::RES_CUR;
               state_in    = ffha_pkg::ST_DONE;
            end
         end
         ffha_pkg::ST_SPLIT: begin
            cmd.wr_op = ffha_pkg::WR_SPLIT_NEW;
            state_in  = ffha_pkg::ST_DONE;
         end
         ffha_pkg::ST_NEXT_RD: begin
            if (status.next_exists) begin
               cmd.rd_next = 1'b1;
               state_in    = ffha_pkg::ST_NEXT_CHK;
            end else begin
               state_in = ffha_pkg::ST_FREE_WR;
            end
         end
         ffha_pkg::ST_NEXT_CHK: begin
            cmd.merge_next = 1'b1;
            state_in       = ffha_pkg::ST_FREE_WR;
         end
         ffha_pkg::ST_FREE_WR: begin
            cmd.wr_op   = ffha_pkg::WR_FREE;
            cmd.res_sel = ffha_pkg::RES_ZERO;
            state_in    = ffha_pkg::ST_DONE;
         end
         ffha_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ffha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::ST_IDLE;
         end
      endcase
   end

   // a block read is always followed by its walk check
   a_chk_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_cur |=> state_ff == ffha_pkg::ST_WALK_CHK)
      else $error("walk check does not follow a block read");

   // an item in flight is never dropped back to idle without a result load
   a_idle_via_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ffha_pkg::ST_IDLE) && !cmd.load_out |=> state_ff != ffha_pkg::ST_IDLE)
      else $error("item left without a result");

endmodule

### hw/rtl/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath of the allocator: block table memory indexed by block offset,
// walk registers, size rounding, split and merge arithmetic, config
// registers and the output register.
// ----------------------------------------------------------------------------
module ffha_dp #(
   parameter int unsigned HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF,
   parameter int unsigned GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF,
   parameter int unsigned HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  ffha_pkg::csr_index_type           csr_index,
   input  logic [ffha_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_action,
   input  logic [ffha_pkg::REQ_W-1:0]        req_bytes,
   input  logic [ffha_pkg::ADDR_W-1:0]       req_payload_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ffha_pkg::ADDR_W-1:0]       rsp_granted_address,
   output logic                              rsp_status,
   input  ffha_pkg::cmd_type                 cmd,
   output ffha_pkg::dp_status_type           status
);

   function automatic int unsigned gcd_f(input int unsigned a, input int unsigned b);
      int unsigned x;
      int unsigned y;
      x = a;
      y = b;
      while (x != y) begin
         if (x > y) x = x - y;
         else       y = y - x;
      end
      return x;
   endfunction

   localparam int unsigned UNIT     = gcd_f(GRANULE_BYTES, HEADER_BYTES);
   localparam int unsigned HDR_U    = HEADER_BYTES / UNIT;
   localparam int unsigned GRAN_U   = GRANULE_BYTES / UNIT;
   localparam int unsigned HEAP_U   = HEAP_BYTES / UNIT;
   localparam int unsigned UW       = $clog2(HEAP_U + 1);
   localparam int unsigned AW       = $clog2(HEAP_U);
   localparam int unsigned XW       = ffha_pkg::REQ_W + 1;
   localparam int unsigned DIV_S    = XW + 9;
   localparam int unsigned RECIP    = ((2 ** DIV_S) + GRANULE_BYTES - 1) / GRANULE_BYTES;
   localparam int unsigned RW       = $clog2(RECIP + 1);
   localparam int unsigned PW       = XW + RW;
   localparam int unsigned QW       = PW - DIV_S;
   localparam int unsigned REQ_MAX  = (2 ** ffha_pkg::REQ_W) - 1;
   localparam int unsigned NEED_MAX = ((REQ_MAX + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRAN_U;
   localparam int unsigned NW       = $clog2(NEED_MAX + 1);
   localparam int unsigned CW       = ((UW > NW) ? UW : NW) + 2;
   localparam int unsigned UNIT_W   = $clog2(UNIT + 1);
   localparam int unsigned SW       = UW + UNIT_W;
   localparam int unsigned TW       = ((SW > ffha_pkg::THR_W) ? SW : ffha_pkg::THR_W);

   // config registers
   logic [ffha_pkg::THR_W-1:0]  thr_ff, thr_in;
   logic [ffha_pkg::ADDR_W-1:0] base_ff, base_in;

   // item and walk registers
   logic                        act_ff, act_in;
   logic [ffha_pkg::REQ_W-1:0]  req_ff, req_in;
   logic [ffha_pkg::ADDR_W-1:0] target_ff, target_in;
   logic [PW-1:0]               prod_ff, prod_in;
   logic [NW-1:0]               need_ff, need_in;
   logic [UW-1:0]               cur_ff, cur_in;
   logic [UW-1:0]               nxt_ff, nxt_in;
   logic [UW-1:0]               cur_size_ff, cur_size_in;
   logic [UW-1:0]               prev_ff, prev_in;
   logic [UW-1:0]               prev_size_ff, prev_size_in;
   logic                        prev_used_ff, prev_used_in;
   logic                        have_prev_ff, have_prev_in;
   logic [UW-1:0]               top_ff, top_in;

   // result and output registers
   logic [ffha_pkg::ADDR_W-1:0] res_grant_ff, res_grant_in;
   logic                        res_status_ff, res_status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ffha_pkg::ADDR_W-1:0] rsp_grant_ff, rsp_grant_in;
   logic                        rsp_status_ff, rsp_status_in;

   // block table: used mark above payload size in units
   logic [UW:0]   blk_mem [0:HEAP_U-1];
   logic [UW:0]   rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [UW:0]   wr_data;

   logic                        rd_used;
   logic [UW-1:0]               rd_size;
   logic [UW:0]                 cur_end;
   logic [UW-1:0]               surplus;
   logic [TW-1:0]               surplus_bytes;
   logic [ffha_pkg::ADDR_W-1:0] cur_bytes;
   logic [ffha_pkg::ADDR_W-1:0] top_bytes;
   logic [XW-1:0]               round_x;
   logic                        full;
   logic                        merge_prev;

   assign rd_used       = rd_data_ff[UW];
   assign rd_size       = rd_data_ff[UW-1:0];
   assign cur_end       = {1'b0, cur_ff} + (UW+1)'(HDR_U) + {1'b0, rd_size};
   assign surplus       = rd_size - UW'(need_ff);
   assign surplus_bytes = TW'(SW'(surplus) * SW'(UNIT));
   assign cur_bytes     = ffha_pkg::ADDR_W'(cur_ff) * ffha_pkg::ADDR_W'(UNIT);
   assign top_bytes     = ffha_pkg::ADDR_W'(top_ff) * ffha_pkg::ADDR_W'(UNIT);
   assign round_x       = XW'(req_ff) + XW'(GRANULE_BYTES - 1);
   assign full          = (CW'(top_ff) + CW'(HDR_U) + CW'(need_ff)) > CW'(HEAP_U);
   assign merge_prev    = have_prev_ff && !prev_used_ff;

   assign status.is_free     = act_ff;
   assign status.at_top      = (cur_ff == top_ff);
   assign status.full        = full;
   assign status.fit         = !rd_used && (CW'(rd_size) >= CW'(need_ff));
   assign status.split_ok    = (surplus_bytes >= TW'(thr_ff)) && (CW'(surplus) >= CW'(HDR_U));
   assign status.hit         = (cur_bytes == target_ff);
   assign status.hit_used    = rd_used;
   assign status.next_exists = (nxt_ff < top_ff);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_grant_ff;
   assign rsp_status          = rsp_status_ff;

   assign rd_en   = cmd.rd_cur || cmd.rd_next;
   assign rd_addr = cmd.rd_next ? nxt_ff[AW-1:0] : cur_ff[AW-1:0];

   always_comb begin
      thr_in        = thr_ff;
      base_in       = base_ff;
      act_in        = act_ff;
      req_in        = req_ff;
      target_in     = target_ff;
      prod_in       = prod_ff;
      need_in       = need_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      cur_size_in   = cur_size_ff;
      prev_in       = prev_ff;
      prev_size_in  = prev_size_ff;
      prev_used_in  = prev_used_ff;
      have_prev_in  = have_prev_ff;
      top_in        = top_ff;
      res_grant_in  = res_grant_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff[AW-1:0];
      wr_data       = {1'b1, rd_size};

      if (csr_wr_en) begin
         unique case (csr_index)
            ffha_pkg::CSR_SPLIT_THRESHOLD: thr_in  = csr_wdata[ffha_pkg::THR_W-1:0];
            ffha_pkg::CSR_HEAP_BASE:       base_in = csr_wdata[ffha_pkg::ADDR_W-1:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         act_in       = req_action;
         req_in       = req_bytes;
         target_in    = req_payload_address - base_ff - ffha_pkg::ADDR_W'(HEADER_BYTES);
         cur_in       = '0;
         have_prev_in = 1'b0;
      end
      if (cmd.calc_mul) begin
         prod_in = PW'(round_x) * PW'(RECIP);
      end
      if (cmd.calc_need) begin
         need_in = NW'(QW'(prod_ff[PW-1:DIV_S]) * (QW + 9)'(GRAN_U));
      end
      if (cmd.advance) begin
         prev_in      = cur_ff;
         prev_size_in = rd_size;
         prev_used_in = rd_used;
         have_prev_in = 1'b1;
         cur_in       = cur_end[UW-1:0];
      end
      if (cmd.hold_next) begin
         nxt_in      = cur_end[UW-1:0];
         cur_size_in = rd_size;
      end
      if (cmd.merge_next && !rd_used) begin
         cur_size_in = cur_size_ff + UW'(HDR_U) + rd_size;
      end

      case (cmd.wr_op)
         ffha_pkg::WR_USE_CUR: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff[AW-1:0];
            wr_data = {1'b1, rd_size};
         end
         ffha_pkg::WR_SPLIT_CUR: begin
            wr_en       = 1'b1;
            wr_addr     = cur_ff[AW-1:0];
            wr_data     = {1'b1, UW'(need_ff)};
            nxt_in      = cur_ff + UW'(HDR_U) + UW'(need_ff);
            cur_size_in = surplus - UW'(HDR_U);
         end
         ffha_pkg::WR_SPLIT_NEW: begin
            wr_en   = 1'b1;
            wr_addr = nxt_ff[AW-1:0];
            wr_data = {1'b0, cur_size_ff};
         end
         ffha_pkg::WR_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = top_ff[AW-1:0];
            wr_data = {1'b1, UW'(need_ff)};
            top_in  = top_ff + UW'(HDR_U) + UW'(need_ff);
         end
         ffha_pkg::WR_FREE: begin
            wr_en = 1'b1;
            if (merge_prev) begin
               wr_addr = prev_ff[AW-1:0];
               wr_data = {1'b0, prev_size_ff + UW'(HDR_U) + cur_size_ff};
            end else begin
               wr_addr = cur_ff[AW-1:0];
               wr_data = {1'b0, cur_size_ff};
            end
         end
         default: ;
      endcase

      case (cmd.res_sel)
         ffha_pkg::RES_ZERO: begin
            res_grant_in  = '0;
            res_status_in = ffha_pkg::RSP_DONE;
         end
         ffha_pkg::RES_OOM: begin
            res_grant_in  = '0;
            res_status_in = ffha_pkg::RSP_OOM;
         end
         ffha_pkg::RES_CUR: begin
            res_grant_in  = base_ff + cur_bytes + ffha_pkg::ADDR_W'(HEADER_BYTES);
            res_status_in = ffha_pkg::RSP_DONE;
         end
         ffha_pkg::RES_TOP: begin
            res_grant_in  = base_ff + top_bytes + ffha_pkg::ADDR_W'(HEADER_BYTES);
            res_status_in = ffha_pkg::RSP_DONE;
         end
         default: ;
      endcase

      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_grant_in  = res_grant_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= ffha_pkg::SPLIT_THRESHOLD_RST;
         base_ff      <= ffha_pkg::HEAP_BASE_RST;
         top_ff       <= '0;
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         base_ff      <= base_in;
         top_ff       <= top_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      target_ff     <= target_in;
      prod_ff       <= prod_in;
      need_ff       <= need_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      cur_size_ff   <= cur_size_in;
      prev_ff       <= prev_in;
      prev_size_ff  <= prev_size_in;
      prev_used_ff  <= prev_used_in;
      have_prev_ff  <= have_prev_in;
      res_grant_ff  <= res_grant_in;
      res_status_ff <= res_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         blk_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= blk_mem[rd_addr];
      end
   end

   a_append_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_op == ffha_pkg::WR_APPEND |-> !full)
      else $error("append past end of heap");

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= UW'(HEAP_U))
      else $error("top offset beyond heap");

   a_oom_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ffha_pkg::RSP_OOM) |-> rsp_grant_ff == '0)
      else $error("out of memory item carries an address");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while held");

endmodule

### hw/rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator for a heap of fixed granules, with split and merge.
// ----------------------------------------------------------------------------
// req channel: tuser is the action (0 allocate, 1 free); tdata carries the
// requested size and the payload address of the block to free.
// rsp channel: one item per request; tdata is the granted payload address
// (zero for free and out of memory), tuser is the status (1 out of memory).
// csr port: index 0 split threshold, index 1 heap base; write while idle.
// Walk: the block table is walked from the lowest block, with one memory
// read and one check per block header. Allocate takes the first free block
// that fits, split when its surplus reaches the split threshold and holds a
// header; with no such block it appends at the top or runs out of memory.
// Free walks to the named block and writes it free, merged with a free next
// block and a free block before it; a block already free or an address that
// names no block is answered with no write. One item is in work at a time;
// the next item can be taken in the cycle after the result is loaded. The
// length of the walk over the block table sets how long an item takes.
// A finished item sits in an output register, so the next item is taken
// while the receiver stalls; the block only waits when a second result is
// done before the first was taken.
// Reset empties the heap (top offset zero) and restores register defaults;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
   parameter int unsigned HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF,
   parameter int unsigned GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF,
   parameter int unsigned HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ffha_pkg::REQ_DATA_W-1:0]   req_tdata,   // request_bytes, payload_address
   input  logic                              req_tuser,   // action
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ffha_pkg::ADDR_W-1:0]       rsp_tdata,   // granted_address
   output logic                              rsp_tuser,   // status
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [ffha_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ffha_pkg::cmd_type       cmd;
   ffha_pkg::dp_status_type status;
   ffha_pkg::csr_index_type csr_sel;

   assign csr_sel = ffha_pkg::csr_index_type'(csr_index);

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ffha_dp #(
      .HEAP_BYTES    (HEAP_BYTES),
      .GRANULE_BYTES (GRANULE_BYTES),
      .HEADER_BYTES  (HEADER_BYTES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_sel),
      .csr_wdata           (csr_wdata),
      .req_action          (req_tuser),
      .req_bytes           (req_tdata[ffha_pkg::REQ_W-1:0]),
      .req_payload_address (req_tdata[ffha_pkg::REQ_W +: ffha_pkg::ADDR_W]),
      .rsp_valid           (rsp_tvalid),
      .rsp_ready           (rsp_tready),
      .rsp_granted_address (rsp_tdata),
      .rsp_status          (rsp_tuser),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule
